FILE: hw/rtl/pdc_pkg.sv
// shared constants, types and register map of the preset pd position controller
`timescale 1ns / 1ps
`default_nettype none

package pdc_pkg;

   // fixed field widths
   localparam int GAIN_W      = 16;
   localparam int PRESET_W    = 24;
   localparam int DRIVE_W     = 8;
   localparam int LEVEL_W     = 3;
   localparam int CMD_W       = 2;
   localparam int FRAC_W      = 16;
   localparam int MAX_PRESETS = 5;

   // parameter defaults
   localparam int POS_WIDTH_DEF   = 24;
   localparam int NUM_PRESETS_DEF = 5;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_P      = 3'd0;
   localparam logic [CSR_ADDR_W-1:0] REG_GAIN_D_RATE = 3'd1;
   localparam logic [CSR_ADDR_W-1:0] REG_DEAD_BAND   = 3'd2;
   localparam logic [CSR_ADDR_W-1:0] REG_PRESET_ZERO = 3'd3;

   // commands
   localparam logic [CMD_W-1:0] CMD_TICK = 2'd0;
   localparam logic [CMD_W-1:0] CMD_UP   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DOWN = 2'd2;

   // drive limits
   localparam int DRIVE_MAX = 127;
   localparam logic signed [DRIVE_W-1:0] DRIVE_POS  = 8'sd127;
   localparam logic signed [DRIVE_W-1:0] DRIVE_NEG  = -8'sd127;
   localparam logic signed [DRIVE_W-1:0] DRIVE_ZERO = 8'sd0;

   // register reset values
   localparam logic [GAIN_W-1:0] GAIN_P_RESET      = 16'd1311;
   localparam logic [GAIN_W-1:0] GAIN_D_RATE_RESET = 16'd1638;
   localparam logic [GAIN_W-1:0] DEAD_BAND_RESET   = 16'd10;

   localparam logic signed [PRESET_W-1:0] PRESET_RESET [MAX_PRESETS] = '{
      24'sd0, 24'sd3400, 24'sd4800, 24'sd15000, 24'sd25000
   };

   typedef struct packed {
      logic [GAIN_W-1:0] gain_p;
      logic [GAIN_W-1:0] gain_d_rate;
      logic [GAIN_W-1:0] dead_band;
   } pdc_gains_type;

   typedef struct packed {
      logic signed [DRIVE_W-1:0] drive;
      logic                      drive_valid;
   } pdc_result_type;

endpackage

`default_nettype wire

FILE: hw/rtl/pdc_if.sv
// request and response channel interfaces of the preset pd position controller
`timescale 1ns / 1ps
`default_nettype none

interface pdc_req_if
   import pdc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF
);
   logic                        valid;
   logic                        ready;
   logic [CMD_W-1:0]            cmd;
   logic signed [POS_WIDTH-1:0] position;
   logic                        manual_hold;
   logic                        raise_button;
   logic                        lower_button;

   modport source (
      output valid, cmd, position, manual_hold, raise_button, lower_button,
      input  ready
   );
   modport sink (
      input  valid, cmd, position, manual_hold, raise_button, lower_button,
      output ready
   );
endinterface

interface pdc_rsp_if
   import pdc_pkg::*;
;
   logic                      valid;
   logic                      ready;
   logic signed [DRIVE_W-1:0] drive;
   logic                      drive_valid;
   logic [LEVEL_W-1:0]        level;

   modport source (
      output valid, drive, drive_valid, level,
      input  ready
   );
   modport sink (
      input  valid, drive, drive_valid, level,
      output ready
   );
endinterface

`default_nettype wire

FILE: hw/rtl/pdc_regs.sv
// configuration registers and preset target select
`timescale 1ns / 1ps
`default_nettype none

module pdc_regs
   import pdc_pkg::*;
#(
   parameter int NUM_PRESETS = NUM_PRESETS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [CSR_ADDR_W-1:0]               csr_index,
   input  wire logic [CSR_DATA_W-1:0]               csr_wdata,
   input  wire logic [$clog2(NUM_PRESETS)-1:0]      sel,
   output pdc_gains_type                            gains,
   output logic signed [PRESET_W-1:0]               target
);

   logic [GAIN_W-1:0]          gain_p_ff, gain_p_in;
   logic [GAIN_W-1:0]          gain_d_rate_ff, gain_d_rate_in;
   logic [GAIN_W-1:0]          dead_band_ff, dead_band_in;
   logic signed [PRESET_W-1:0] preset_ff [NUM_PRESETS];
   logic signed [PRESET_W-1:0] preset_in [NUM_PRESETS];

   always_comb begin
      gain_p_in      = gain_p_ff;
      gain_d_rate_in = gain_d_rate_ff;
      dead_band_in   = dead_band_ff;
      if (csr_we && csr_index == REG_GAIN_P) begin
         gain_p_in = csr_wdata[GAIN_W-1:0];
      end
      if (csr_we && csr_index == REG_GAIN_D_RATE) begin
         gain_d_rate_in = csr_wdata[GAIN_W-1:0];
      end
      if (csr_we && csr_index == REG_DEAD_BAND) begin
         dead_band_in = csr_wdata[GAIN_W-1:0];
      end
      for (int i = 0; i < NUM_PRESETS; i++) begin
         preset_in[i] = preset_ff[i];
         if (csr_we && csr_index == REG_PRESET_ZERO + CSR_ADDR_W'(i)) begin
            preset_in[i] = $signed(csr_wdata[PRESET_W-1:0]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff      <= GAIN_P_RESET;
         gain_d_rate_ff <= GAIN_D_RATE_RESET;
         dead_band_ff   <= DEAD_BAND_RESET;
         for (int i = 0; i < NUM_PRESETS; i++) begin
            preset_ff[i] <= PRESET_RESET[i];
         end
      end else begin
         gain_p_ff      <= gain_p_in;
         gain_d_rate_ff <= gain_d_rate_in;
         dead_band_ff   <= dead_band_in;
         for (int i = 0; i < NUM_PRESETS; i++) begin
            preset_ff[i] <= preset_in[i];
         end
      end
   end

   assign gains.gain_p      = gain_p_ff;
   assign gains.gain_d_rate = gain_d_rate_ff;
   assign gains.dead_band   = dead_band_ff;
   assign target            = preset_ff[sel];

endmodule

`default_nettype wire

FILE: hw/rtl/pdc_law.sv
// pd control law: error, weighted sum, truncation, saturation, dead band and manual drive
`timescale 1ns / 1ps
`default_nettype none

module pdc_law
   import pdc_pkg::*;
#(
   parameter int POS_WIDTH = POS_WIDTH_DEF,
   localparam int ERR_W = ((POS_WIDTH > PRESET_W) ? POS_WIDTH : PRESET_W) + 1
) (
   input  wire logic [CMD_W-1:0]            cmd,
   input  wire logic signed [POS_WIDTH-1:0] position,
   input  wire logic                        manual_hold,
   input  wire logic                        raise_button,
   input  wire logic                        lower_button,
   input  wire logic signed [PRESET_W-1:0]  target,
   input  wire logic signed [ERR_W-1:0]     last_error,
   input  wire pdc_gains_type               gains,
   output logic signed [ERR_W-1:0]          error,
   output pdc_result_type                   result
);

   localparam int ACC_W = ERR_W + 19;
   localparam int Q_W   = ACC_W - FRAC_W;
   localparam logic signed [Q_W-1:0] Q_MAX = Q_W'(DRIVE_MAX);
   localparam logic signed [Q_W-1:0] Q_MIN = -Q_MAX;

   logic signed [ERR_W-1:0]  pos_ext, tgt_ext;
   logic signed [ERR_W:0]    diff;
   logic signed [GAIN_W:0]   gp_s, gd_s;
   logic signed [ERR_W+16:0] prod_p;
   logic signed [ERR_W+17:0] prod_d;
   logic signed [ACC_W-1:0]  acc;
   logic signed [Q_W-1:0]    quot;
   logic                     round_up;
   logic signed [DRIVE_W-1:0] sat, manual_drive;
   logic [ERR_W-1:0]         mag;
   logic                     over_band;

   assign pos_ext = $signed({{(ERR_W-POS_WIDTH){position[POS_WIDTH-1]}}, position});
   assign tgt_ext = $signed({{(ERR_W-PRESET_W){target[PRESET_W-1]}}, target});
   assign error   = tgt_ext - pos_ext;
   assign diff    = $signed({error[ERR_W-1], error})
                  - $signed({last_error[ERR_W-1], last_error});

   assign gp_s   = $signed({1'b0, gains.gain_p});
   assign gd_s   = $signed({1'b0, gains.gain_d_rate});
   assign prod_p = gp_s * error;
   assign prod_d = gd_s * diff;
   assign acc    = $signed({{2{prod_p[ERR_W+16]}}, prod_p})
                 + $signed({prod_d[ERR_W+17], prod_d});

   // shift floors, so step up by one for a negative sum with a fraction
   assign round_up = acc[ACC_W-1] && (|acc[FRAC_W-1:0]);
   assign quot     = acc[ACC_W-1:FRAC_W] + $signed({{(Q_W-1){1'b0}}, round_up});

   always_comb begin
      if (quot > Q_MAX) begin
         sat = DRIVE_POS;
      end else if (quot < Q_MIN) begin
         sat = DRIVE_NEG;
      end else begin
         sat = quot[DRIVE_W-1:0];
      end
   end

   assign mag          = error[ERR_W-1] ? ERR_W'(-error) : ERR_W'(error);
   assign over_band    = mag > {{(ERR_W-GAIN_W){1'b0}}, gains.dead_band};
   assign manual_drive = raise_button ? DRIVE_POS : (lower_button ? DRIVE_NEG : DRIVE_ZERO);

   always_comb begin
      result.drive       = DRIVE_ZERO;
      result.drive_valid = 1'b0;
      case (cmd)
         CMD_TICK: begin
            if (manual_hold) begin
               result.drive       = manual_drive;
               result.drive_valid = 1'b1;
            end else if (over_band) begin
               result.drive       = sat;
               result.drive_valid = 1'b1;
            end
         end
         default: begin
            result.drive       = DRIVE_ZERO;
            result.drive_valid = 1'b0;
         end
      endcase
   end

endmodule

`default_nettype wire

FILE: hw/rtl/preset_pd_position_controller.sv
// top level of the preset pd position controller
//
//   channel   dir   handshake          payload
//   req_bus   in    valid / ready      cmd, position, manual_hold, raise_button, lower_button
//   rsp_bus   out   valid / ready      drive, drive_valid, level
//   csr_*     in    csr_we             csr_index, csr_wdata (write only)
//
// one request per cycle sustained while rsp_bus.ready stays high; a request passes the input
// register, then the control law into the result register, before its result is valid
// synchronous reset clears the preset index, last error and valid bits and
// reloads the gains, dead band and presets with their reset values
// the input register keeps taking requests while a result waits; only when both
// the result register and the input register are full and rsp_bus.ready is low does req_bus.ready drop
`timescale 1ns / 1ps
`default_nettype none

module preset_pd_position_controller
   import pdc_pkg::*;
#(
   parameter int POS_WIDTH   = POS_WIDTH_DEF,
   parameter int NUM_PRESETS = NUM_PRESETS_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   pdc_req_if.sink                    req_bus,
   pdc_rsp_if.source                  rsp_bus,
   input  wire logic                  csr_we,
   input  wire logic [CSR_ADDR_W-1:0] csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ERR_W = ((POS_WIDTH > PRESET_W) ? POS_WIDTH : PRESET_W) + 1;
   localparam int SEL_W = $clog2(NUM_PRESETS);
   localparam logic [LEVEL_W-1:0] TOP_LEVEL = LEVEL_W'(NUM_PRESETS - 1);

   // input register
   logic                        in_valid_ff, in_valid_in;
   logic [CMD_W-1:0]            in_cmd_ff;
   logic signed [POS_WIDTH-1:0] in_position_ff;
   logic                        in_manual_ff, in_raise_ff, in_lower_ff;

   // controller state
   logic [LEVEL_W-1:0]          preset_index_ff, preset_index_in;
   logic signed [ERR_W-1:0]     last_error_ff, last_error_in;

   // result register
   logic                        out_valid_ff, out_valid_in;
   logic signed [DRIVE_W-1:0]   out_drive_ff;
   logic                        out_drive_valid_ff;
   logic [LEVEL_W-1:0]          out_level_ff;

   logic                        accept, advance;
   pdc_gains_type               gains;
   logic signed [PRESET_W-1:0]  target;
   logic signed [ERR_W-1:0]     error;
   pdc_result_type              result;

   // handshake: the input slot drains into the result register when it is free or being read out
   assign advance       = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready = !in_valid_ff || advance;
   assign accept        = req_bus.valid && req_bus.ready;

   pdc_regs #(
      .NUM_PRESETS (NUM_PRESETS)
   ) u_regs (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .sel       (preset_index_ff[SEL_W-1:0]),
      .gains     (gains),
      .target    (target)
   );

   pdc_law #(
      .POS_WIDTH (POS_WIDTH)
   ) u_law (
      .cmd          (in_cmd_ff),
      .position     (in_position_ff),
      .manual_hold  (in_manual_ff),
      .raise_button (in_raise_ff),
      .lower_button (in_lower_ff),
      .target       (target),
      .last_error   (last_error_ff),
      .gains        (gains),
      .error        (error),
      .result       (result)
   );

   // state update for the request leaving the input slot
   always_comb begin
      preset_index_in = preset_index_ff;
      last_error_in   = last_error_ff;
      if (advance) begin
         case (in_cmd_ff)
            CMD_UP: begin
               if (preset_index_ff < TOP_LEVEL) begin
                  preset_index_in = preset_index_ff + LEVEL_W'(1);
               end
            end
            CMD_DOWN: begin
               if (preset_index_ff != '0) begin
                  preset_index_in = preset_index_ff - LEVEL_W'(1);
               end
            end
            CMD_TICK: begin
               // saved on manual and automatic ticks alike
               last_error_in = error;
            end
            default: begin
               preset_index_in = preset_index_ff;
            end
         endcase
      end
   end

   assign in_valid_in  = accept ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign out_valid_in = advance ? 1'b1 : (rsp_bus.ready ? 1'b0 : out_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         preset_index_ff <= '0;
         last_error_ff   <= '0;
      end else begin
         in_valid_ff     <= in_valid_in;
         out_valid_ff    <= out_valid_in;
         preset_index_ff <= preset_index_in;
         last_error_ff   <= last_error_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         in_cmd_ff      <= req_bus.cmd;
         in_position_ff <= req_bus.position;
         in_manual_ff   <= req_bus.manual_hold;
         in_raise_ff    <= req_bus.raise_button;
         in_lower_ff    <= req_bus.lower_button;
      end
      if (advance) begin
         out_drive_ff       <= result.drive;
         out_drive_valid_ff <= result.drive_valid;
         out_level_ff       <= preset_index_in;
      end
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.drive       = out_drive_ff;
   assign rsp_bus.drive_valid = out_drive_valid_ff;
   assign rsp_bus.level       = out_level_ff;

   // the preset index only moves when a request is processed
   a_index_moves_on_advance: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(preset_index_ff))
      else $error("preset index changed without a request");

   // the preset index never leaves its range
   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      preset_index_ff <= TOP_LEVEL)
      else $error("preset index out of range");

   // an unissued drive reads as zero
   a_no_drive_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && !rsp_bus.drive_valid |-> rsp_bus.drive == DRIVE_ZERO)
      else $error("drive nonzero without drive_valid");

   // saturation keeps the drive off the most negative code
   a_drive_saturated: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> rsp_bus.drive >= DRIVE_NEG)
      else $error("drive outside saturation range");

   // a step request leaves the last error alone
   a_step_keeps_error: assert property (@(posedge clock) disable iff (reset)
      advance && (in_cmd_ff == CMD_UP || in_cmd_ff == CMD_DOWN) |=> $stable(last_error_ff))
      else $error("last error changed on a step request");

endmodule

`default_nettype wire

FILE: sim/preset_pd_position_controller_test.sv
// self-checking testbench of the preset pd position controller: directed rows, then random phases
`timescale 1ns / 1ps

module preset_pd_position_controller_test;
   import pdc_pkg::*;

   localparam int POS_W     = POS_WIDTH_DEF;
   localparam int TOP_LEVEL = NUM_PRESETS_DEF - 1;
   localparam int ROWS      = 25;
   localparam int PHASES    = 5;
   localparam int PER_PHASE = 80;

   // cmd value with no meaning: the block must leave its state alone
   localparam logic [CMD_W-1:0] CMD_SPARE = 2'd3;

   typedef struct {
      logic [CMD_W-1:0]        cmd;
      logic signed [POS_W-1:0] position;
      logic                    manual_hold;
      logic                    raise_button;
      logic                    lower_button;
   } lift_request_type;

   typedef struct {
      logic signed [DRIVE_W-1:0] drive;
      logic                      drive_valid;
      logic [LEVEL_W-1:0]        level;
   } lift_result_type;

   // one directed row: the request, and a typed-in result where it is obvious
   typedef struct {
      logic [CMD_W-1:0]          cmd;
      logic signed [POS_W-1:0]   position;
      logic                      manual_hold;
      logic                      raise_button;
      logic                      lower_button;
      logic                      typed;
      logic signed [DRIVE_W-1:0] drive;
      logic                      drive_valid;
      logic [LEVEL_W-1:0]        level;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_we;
   logic [CSR_ADDR_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   pdc_req_if #(.POS_WIDTH(POS_W)) req_bus ();
   pdc_rsp_if rsp_bus ();

   preset_pd_position_controller #(
      .POS_WIDTH   (POS_W),
      .NUM_PRESETS (NUM_PRESETS_DEF)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // 10 ns clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // shadow copy of the controller: settings, preset index and last error
   logic [GAIN_W-1:0]          gain_p;
   logic [GAIN_W-1:0]          gain_d_rate;
   logic [GAIN_W-1:0]          dead_band;
   logic signed [PRESET_W-1:0] preset_target [MAX_PRESETS];
   logic [LEVEL_W-1:0]         lift_level;
   logic signed [25:0]         prior_error;

   lift_result_type drive_expect_q [$];
   int  fault_count;
   bit  gaps_on;

   // directed rows, walked in order right after reset with reset settings
   script_row_type script [ROWS] = '{
      // settled at preset zero, then just inside the deadband
      '{CMD_TICK,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd0},
      '{CMD_TICK,  24'sd5,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd0},
      // step down at the floor holds the index
      '{CMD_DOWN,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd0},
      // manual mode: raise wins over lower, lower alone, no button
      '{CMD_TICK,  24'sd0,     1'b1, 1'b1, 1'b1, 1'b1, DRIVE_POS,  1'b1, 3'd0},
      '{CMD_TICK,  24'sd0,     1'b1, 1'b0, 1'b1, 1'b1, DRIVE_NEG,  1'b1, 3'd0},
      '{CMD_TICK,  24'sd0,     1'b1, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b1, 3'd0},
      // position extremes saturate the drive
      '{CMD_TICK,  24'h7FFFFF, 1'b0, 1'b1, 1'b1, 1'b1, DRIVE_NEG,  1'b1, 3'd0},
      '{CMD_TICK,  24'h800000, 1'b0, 1'b0, 1'b0, 1'b1, DRIVE_POS,  1'b1, 3'd0},
      // unused cmd changes nothing
      '{CMD_SPARE, 24'h7FFFFF, 1'b1, 1'b1, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd0},
      // walk up to the ceiling and once past it
      '{CMD_UP,    24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd1},
      '{CMD_UP,    24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd2},
      '{CMD_UP,    24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd3},
      '{CMD_UP,    24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd4},
      '{CMD_UP,    24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd4},
      // at preset four: on target, error equal to the deadband, one past it
      '{CMD_TICK,  24'sd25000, 1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd4},
      '{CMD_TICK,  24'sd24990, 1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd4},
      '{CMD_TICK,  24'sd24989, 1'b0, 1'b0, 1'b0, 1'b0, DRIVE_ZERO, 1'b0, 3'd0},
      '{CMD_TICK,  24'sd22000, 1'b0, 1'b0, 1'b1, 1'b0, DRIVE_ZERO, 1'b0, 3'd0},
      '{CMD_TICK, -24'sd5,     1'b1, 1'b1, 1'b0, 1'b1, DRIVE_POS,  1'b1, 3'd4},
      '{CMD_TICK,  24'sd25100, 1'b0, 1'b0, 1'b0, 1'b0, DRIVE_ZERO, 1'b0, 3'd0},
      // walk back down to the floor
      '{CMD_DOWN,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd3},
      '{CMD_DOWN,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd2},
      '{CMD_DOWN,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd1},
      '{CMD_DOWN,  24'sd0,     1'b0, 1'b0, 1'b0, 1'b1, DRIVE_ZERO, 1'b0, 3'd0},
      '{CMD_TICK, -24'sd300,   1'b0, 1'b1, 1'b1, 1'b0, DRIVE_ZERO, 1'b0, 3'd0}
   };

   // control law of one request; updates the shadow index and last error
   function automatic lift_result_type predict_lift_drive(lift_request_type r);
      longint err;
      longint acc;
      longint law;
      longint mag;
      lift_result_type e;
      e.drive       = DRIVE_ZERO;
      e.drive_valid = 1'b0;
      case (r.cmd)
         CMD_UP: begin
            if (lift_level < TOP_LEVEL) lift_level = lift_level + 1'b1;
         end
         CMD_DOWN: begin
            if (lift_level != 0) lift_level = lift_level - 1'b1;
         end
         CMD_TICK: begin
            err = longint'(preset_target[lift_level]) - longint'(r.position);
            if (r.manual_hold) begin
               e.drive = r.raise_button ? DRIVE_POS : (r.lower_button ? DRIVE_NEG : DRIVE_ZERO);
               e.drive_valid = 1'b1;
            end else begin
               acc = longint'(gain_p) * err
                   + longint'(gain_d_rate) * (err - longint'(prior_error));
               // signed divide truncates toward zero
               law = acc / (longint'(1) << FRAC_W);
               if (law > DRIVE_MAX) law = DRIVE_MAX;
               if (law < -DRIVE_MAX) law = -DRIVE_MAX;
               mag = (err < 0) ? -err : err;
               if (mag > longint'(dead_band)) begin
                  e.drive       = law[DRIVE_W-1:0];
                  e.drive_valid = 1'b1;
               end
            end
            prior_error = err[25:0];
         end
         default: ;
      endcase
      e.level = lift_level;
      return e;
   endfunction

   // random request, mostly ticks aimed around the current target
   function automatic lift_request_type make_lift_request();
      lift_request_type r;
      int     pick;
      int     mode;
      longint aim;
      longint offs;
      pick = $urandom_range(99);
      r.cmd          = (pick < 9) ? CMD_UP : (pick < 18) ? CMD_DOWN :
                       (pick < 22) ? CMD_SPARE : CMD_TICK;
      r.manual_hold  = ($urandom_range(7) == 0);
      r.raise_button = 1'($urandom_range(1));
      r.lower_button = 1'($urandom_range(1));
      aim  = longint'(preset_target[lift_level]);
      mode = $urandom_range(9);
      if (mode < 2) begin
         // anywhere in the sensor range
         r.position = POS_W'($urandom);
      end else if (mode < 5) begin
         // hugging the deadband edge on either side
         offs = longint'(dead_band) + $urandom_range(0, 6) - 3;
         if ($urandom_range(1)) offs = -offs;
         aim = aim - offs;
         r.position = aim[POS_W-1:0];
      end else begin
         // near the target, mostly in the unsaturated region
         offs = $urandom_range(0, 8000);
         if ($urandom_range(1)) offs = -offs;
         aim = aim + offs;
         r.position = aim[POS_W-1:0];
      end
      return r;
   endfunction

   // one request through the handshake, predicted at acceptance
   task automatic send_request(input lift_request_type r, input bit typed,
                               input lift_result_type typed_result);
      lift_result_type e;
      @(negedge clock);
      req_bus.valid        = 1'b1;
      req_bus.cmd          = r.cmd;
      req_bus.position     = r.position;
      req_bus.manual_hold  = r.manual_hold;
      req_bus.raise_button = r.raise_button;
      req_bus.lower_button = r.lower_button;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      e = predict_lift_drive(r);
      drive_expect_q.push_back(typed ? typed_result : e);
   endtask

   // sender gap: req_bus.valid is dropped for the length that the argument gives
   task automatic pause_requests(input int cycles);
      @(negedge clock);
      req_bus.valid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // stop sending and wait until every expected result is back
   task automatic drain_results();
      @(negedge clock);
      req_bus.valid = 1'b0;
      while (drive_expect_q.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_ADDR_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_we    = 1'b1;
      csr_index = idx;
      csr_wdata = value;
      @(posedge clock);
      case (idx)
         REG_GAIN_P:      gain_p      = value[GAIN_W-1:0];
         REG_GAIN_D_RATE: gain_d_rate = value[GAIN_W-1:0];
         REG_DEAD_BAND:   dead_band   = value[GAIN_W-1:0];
         default:         preset_target[idx - REG_PRESET_ZERO] = value;
      endcase
   endtask

   // gains get junk in the unused upper byte; the block must drop it
   function automatic logic [CSR_DATA_W-1:0] gain_word(input logic [GAIN_W-1:0] g);
      logic [CSR_DATA_W-1:0] w;
      w = CSR_DATA_W'($urandom);
      w[GAIN_W-1:0] = g;
      return w;
   endfunction

   // every register written once per phase; phases 0 and 1 sit at the extremes
   task automatic apply_settings(input int phase);
      logic [GAIN_W-1:0]          gp;
      logic [GAIN_W-1:0]          gd;
      logic [GAIN_W-1:0]          db;
      logic signed [PRESET_W-1:0] goal [MAX_PRESETS];
      case (phase)
         0: begin
            gp = 16'hFFFF;
            gd = 16'hFFFF;
            db = 16'h0000;
            goal = '{24'h7FFFFF, 24'h800000, 24'h000000, 24'h000001, 24'hFFFFFF};
         end
         1: begin
            gp = 16'h0000;
            gd = 16'h0000;
            db = 16'hFFFF;
            goal = '{24'h800000, 24'h7FFFFF, 24'hFFFFFF, 24'h000000, 24'h400000};
         end
         2: begin
            gp = GAIN_W'($urandom_range(0, 4000));
            gd = GAIN_W'($urandom_range(0, 65535));
            db = GAIN_W'($urandom_range(0, 300));
            for (int i = 0; i < MAX_PRESETS; i++) goal[i] = PRESET_W'($urandom);
         end
         3: begin
            gp = GAIN_P_RESET;
            gd = GAIN_D_RATE_RESET;
            db = GAIN_W'($urandom_range(0, 40));
            goal = PRESET_RESET;
         end
         default: begin
            gp = GAIN_W'($urandom_range(0, 65535));
            gd = GAIN_W'($urandom_range(0, 4000));
            db = GAIN_W'($urandom_range(0, 50));
            for (int i = 0; i < MAX_PRESETS; i++)
               goal[i] = PRESET_W'($urandom_range(0, 60000) - 30000);
         end
      endcase
      write_register(REG_GAIN_P, gain_word(gp));
      write_register(REG_GAIN_D_RATE, gain_word(gd));
      write_register(REG_DEAD_BAND, gain_word(db));
      for (int i = 0; i < MAX_PRESETS; i++)
         write_register(REG_PRESET_ZERO + i[CSR_ADDR_W-1:0], goal[i]);
      @(negedge clock);
      csr_we = 1'b0;
   endtask

   // response side: random stall bursts while gaps are enabled
   initial begin
      int stall_left;
      stall_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left > 0) begin
            rsp_bus.ready = 1'b0;
            stall_left--;
         end else if (gaps_on && $urandom_range(4) == 0) begin
            rsp_bus.ready = 1'b0;
            stall_left = $urandom_range(1, 13) - 1;
         end else begin
            rsp_bus.ready = 1'b1;
         end
      end
   end

   // each accepted result against the oldest expectation, field by field
   always @(posedge clock) begin
      lift_result_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (drive_expect_q.size() == 0) begin
            $error("result with no request outstanding: drive %0d drive_valid %0b level %0d",
                   rsp_bus.drive, rsp_bus.drive_valid, rsp_bus.level);
            fault_count++;
         end else begin
            want = drive_expect_q.pop_front();
            if (rsp_bus.drive !== want.drive) begin
               $error("drive: expected %0d, got %0d", want.drive, rsp_bus.drive);
               fault_count++;
            end
            if (rsp_bus.drive_valid !== want.drive_valid) begin
               $error("drive_valid: expected %0b, got %0b", want.drive_valid,
                      rsp_bus.drive_valid);
               fault_count++;
            end
            if (rsp_bus.level !== want.level) begin
               $error("level: expected %0d, got %0d", want.level, rsp_bus.level);
               fault_count++;
            end
         end
      end
   end

   // main sequence
   initial begin
      lift_request_type r;
      lift_result_type  t;
      int               last_phase;
      fault_count   = 0;
      gaps_on       = 1'b1;
      reset         = 1'b1;
      csr_we        = 1'b0;
      csr_index     = '0;
      csr_wdata     = '0;
      req_bus.valid        = 1'b0;
      req_bus.cmd          = CMD_TICK;
      req_bus.position     = '0;
      req_bus.manual_hold  = 1'b0;
      req_bus.raise_button = 1'b0;
      req_bus.lower_button = 1'b0;
      // shadow state after reset
      gain_p        = GAIN_P_RESET;
      gain_d_rate   = GAIN_D_RATE_RESET;
      dead_band     = DEAD_BAND_RESET;
      preset_target = PRESET_RESET;
      lift_level    = '0;
      prior_error   = '0;
      last_phase    = PHASES - 1;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed rows with reset settings
      foreach (script[k]) begin
         r.cmd          = script[k].cmd;
         r.position     = script[k].position;
         r.manual_hold  = script[k].manual_hold;
         r.raise_button = script[k].raise_button;
         r.lower_button = script[k].lower_button;
         t.drive        = script[k].drive;
         t.drive_valid  = script[k].drive_valid;
         t.level        = script[k].level;
         send_request(r, script[k].typed, t);
         if ($urandom_range(3) == 0) pause_requests($urandom_range(1, 13));
      end
      drain_results();

      // random phases, each under its own settings; the last one runs with no gaps
      for (int phase = 0; phase < PHASES; phase++) begin
         apply_settings(phase);
         for (int n = 0; n < PER_PHASE; n++) begin
            // gaps switch on and off in stretches of 20 requests
            if (n % 20 == 0) gaps_on = (phase != last_phase) && ($urandom_range(3) != 0);
            // once, hold the sender until the pipeline is empty
            if (phase == 2 && n == PER_PHASE / 2) drain_results();
            r = make_lift_request();
            send_request(r, 1'b0, t);
            if (gaps_on && $urandom_range(3) == 0) pause_requests($urandom_range(1, 13));
         end
         // no new stall bursts from here on when the gap-free phase comes next
         if (phase + 1 == last_phase) gaps_on = 1'b0;
         drain_results();
      end

      // wait for any stray result to show up
      repeat (4) @(posedge clock);
      if (fault_count == 0) begin
         $display("preset_pd_position_controller test passed");
      end else begin
         $display("preset_pd_position_controller test failed");
      end
      $finish;
   end

   // hard stop well beyond the slowest legal run
   initial begin
      #2_000_000;
      $display("preset_pd_position_controller test failed");
      $finish;
   end

endmodule
